/* sv/per_key_event_threshold_table_assert.svh */
// Assertion macros for the checker file of this block.
`ifndef PER_KEY_EVENT_THRESHOLD_TABLE_ASSERT_SVH
`define PER_KEY_EVENT_THRESHOLD_TABLE_ASSERT_SVH

// Clocked assertion that is switched off while the reset is active.
`define PKET_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("pket assertion failed");

// Clocked assertion that also holds during reset.
`define PKET_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("pket assertion failed");

`endif

/* sv/pket_pkg.sv */
`default_nettype none
package pket_pkg;

  localparam int ENTRIES = 16;
  localparam int SLOT_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  localparam int PID_W = 22;
  localparam int CNT_W = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam int TDATA_IN_W  = 24;
  localparam int TDATA_OUT_W = 16;
  localparam int TUSER_OUT_W = 2;

  localparam logic [CNT_W-1:0] THRESHOLD_RESET = 16'd100;
  localparam logic [PID_W-1:0] MIN_ID_RESET    = 22'd8000;

  // APB register map: register i at byte address 4*i.
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam int REG_IDX_W  = 1;
  localparam logic [REG_IDX_W-1:0] REG_ACCESS_THRESHOLD = 1'b0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_FLAG_ID      = 1'b1;

  // Queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [PID_W-1:0] pid;
    logic             counted;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] threshold;
    logic [PID_W-1:0] min_id;
  } cfg_t;

endpackage
`default_nettype wire

/* sv/pket_front.sv */
`default_nettype none
module pket_front (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             s_tvalid_i,
  output logic                            s_tready_o,
  input  wire  [pket_pkg::TDATA_IN_W-1:0] s_tdata_i,   // event_pid, zero pad
  input  wire                             s_tuser_i,   // is_modify
  output pket_pkg::item_t                 item_o,
  output logic                            item_valid_o,
  input  wire                             item_ready_i
);
  import pket_pkg::*;

  logic             valid_q, valid_d;
  item_t            item_q, item_d;
  logic [PID_W-1:0] pid;

  assign pid          = s_tdata_i[PID_W-1:0];
  assign s_tready_o   = !valid_q || item_ready_i;
  assign item_o       = item_q;
  assign item_valid_o = valid_q;

  // Only modify events with a nonzero id touch the table.
  always_comb begin
    valid_d = valid_q;
    item_d  = item_q;
    if (valid_q && item_ready_i) begin
      valid_d = 1'b0;
    end
    if (s_tvalid_i && s_tready_o) begin
      valid_d      = 1'b1;
      item_d.pid   = pid;
      item_d.counted = s_tuser_i && (pid != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

endmodule
`default_nettype wire

/* sv/pket_fifo.sv */
`default_nettype none
module pket_fifo (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  pket_pkg::item_t  push_item_i,
  input  wire              push_valid_i,
  output logic             push_ready_o,
  output pket_pkg::item_t  pop_item_o,
  output logic             pop_valid_o,
  input  wire              pop_ready_i
);
  import pket_pkg::*;

  item_t              mem_q [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]  cnt_q, cnt_d;
  logic               push, pop;

  assign push_ready_o = (cnt_q != QCNT_W'(QDEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

/* sv/pket_back.sv */
`default_nettype none
module pket_back (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  pket_pkg::cfg_t                   cfg_i,
  input  pket_pkg::item_t                  item_i,
  input  wire                              item_valid_i,
  output logic                             item_ready_o,
  output logic                             m_tvalid_o,
  input  wire                              m_tready_i,
  output logic [pket_pkg::TDATA_OUT_W-1:0] m_tdata_o,  // count
  output logic [pket_pkg::TUSER_OUT_W-1:0] m_tuser_o   // terminate, table_full
);
  import pket_pkg::*;

  typedef enum logic {
    S_MATCH,
    S_UPDATE
  } state_e;

  state_e            state_q;
  logic [PID_W-1:0]  key_q   [ENTRIES];
  logic [CNT_W-1:0]  count_q [ENTRIES];

  logic [PID_W-1:0]  pid_q;
  logic              counted_q;
  logic              hit_q;
  logic              any_free_q;
  logic [SLOT_W-1:0] slot_q;

  logic              out_valid_q;
  logic [CNT_W-1:0]  out_count_q;
  logic              out_term_q;
  logic              out_full_q;

  logic [ENTRIES-1:0] hit_vec, free_vec, free_low;
  logic [SLOT_W-1:0]  hit_idx, free_idx;
  logic               out_free;
  logic [CNT_W-1:0]   cur_cnt, new_cnt;
  logic               drop;
  logic               term;
  logic               out_load;
  logic               apply;

  // Each slot compares its own key in parallel.
  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      hit_vec[i]  = (key_q[i] == item_i.pid);
      free_vec[i] = (key_q[i] == '0);
    end
  end

  // Lowest free slot: isolate the lowest set bit.
  assign free_low = free_vec & (~free_vec + 1'b1);

  // Keys are unique, so at most one hit bit is set and an OR encode works.
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit_vec[i]) begin
        hit_idx = hit_idx | SLOT_W'(i);
      end
      if (free_low[i]) begin
        free_idx = free_idx | SLOT_W'(i);
      end
    end
  end

  assign item_ready_o = (state_q == S_MATCH);
  assign out_free     = !out_valid_q || m_tready_i;

  assign cur_cnt  = count_q[slot_q];
  assign new_cnt  = (cur_cnt == CNT_MAX) ? cur_cnt : cur_cnt + 1'b1;
  assign drop     = !hit_q && !any_free_q;
  assign term     = (new_cnt >= cfg_i.threshold) && (pid_q > cfg_i.min_id);
  assign out_load = (state_q == S_UPDATE) && out_free;
  assign apply    = counted_q && !drop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_MATCH;
      out_valid_q <= 1'b0;
      out_count_q <= '0;
      out_term_q  <= 1'b0;
      out_full_q  <= 1'b0;
      pid_q       <= '0;
      counted_q   <= 1'b0;
      hit_q       <= 1'b0;
      any_free_q  <= 1'b0;
      slot_q      <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        key_q[i]   <= '0;
        count_q[i] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_MATCH: begin
          if (item_valid_i) begin
            pid_q      <= item_i.pid;
            counted_q  <= item_i.counted;
            hit_q      <= |hit_vec;
            any_free_q <= |free_vec;
            slot_q     <= (|hit_vec) ? hit_idx : free_idx;
            state_q    <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          // Wait here while the previous result beat is still held.
          if (out_free) begin
            out_count_q <= apply ? new_cnt : '0;
            out_term_q  <= apply && term;
            out_full_q  <= counted_q && drop;
            if (apply) begin
              key_q[slot_q]   <= pid_q;
              count_q[slot_q] <= new_cnt;
            end
            state_q <= S_MATCH;
          end
        end
        default: begin
          state_q <= S_MATCH;
        end
      endcase
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = out_count_q;
  assign m_tuser_o  = {out_full_q, out_term_q};

endmodule
`default_nettype wire

/* sv/per_key_event_threshold_table.sv */
// Per-id event counter with a termination threshold.
// Input channel s_axis_*: one beat per event, tdata carries the process id
// and tuser the modify flag. Output channel m_axis_*: exactly one beat per
// input beat, in order, with the id's count in tdata and the terminate and
// table-full flags in tuser.
// The id table has 16 slots searched in parallel; a new id takes the lowest
// free slot, and slots are never freed. A full table drops a counted event
// of a new id and sets table_full.
// An input beat passes the input register, the queue, the match and update
// states of the back-end sequencer and the output register. The sequencer
// takes a new event only after it has updated the table for the last one.
// A two-entry queue and an input register sit between the channels, so a few
// events are taken while the receiver stalls; once they fill, s_axis_tready
// drops and the held output beat stays stable until taken.
// Reset clears the table and loads the threshold (100) and minimum id (8000).
// Registers on APB: access_threshold at 0x0, min_flag_id at 0x4; write them
// only while no event is in flight.
`default_nettype none
module per_key_event_threshold_table (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire  [pket_pkg::TDATA_IN_W-1:0]  s_axis_tdata,   // event_pid, zero pad
  input  wire                              s_axis_tuser,   // is_modify
  output logic                             m_axis_tvalid,
  input  wire                              m_axis_tready,
  output logic [pket_pkg::TDATA_OUT_W-1:0] m_axis_tdata,   // count
  output logic [pket_pkg::TUSER_OUT_W-1:0] m_axis_tuser,   // terminate, table_full
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire  [pket_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire  [pket_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [pket_pkg::APB_DATA_W-1:0]  prdata,
  output logic                             pready
);
  import pket_pkg::*;

  cfg_t                 cfg_q;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 wr_en;

  item_t front_item, fifo_item;
  logic  front_valid, front_ready;
  logic  fifo_valid, fifo_ready;

  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold <= THRESHOLD_RESET;
      cfg_q.min_id    <= MIN_ID_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ACCESS_THRESHOLD: cfg_q.threshold <= pwdata[CNT_W-1:0];
        REG_MIN_FLAG_ID:      cfg_q.min_id    <= pwdata[PID_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ACCESS_THRESHOLD: prdata = APB_DATA_W'(cfg_q.threshold);
      REG_MIN_FLAG_ID:      prdata = APB_DATA_W'(cfg_q.min_id);
      default:              prdata = '0;
    endcase
  end

  pket_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_axis_tvalid),
    .s_tready_o   (s_axis_tready),
    .s_tdata_i    (s_axis_tdata),
    .s_tuser_i    (s_axis_tuser),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  pket_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_item_i  (front_item),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_item_o   (fifo_item),
    .pop_valid_o  (fifo_valid),
    .pop_ready_i  (fifo_ready)
  );

  pket_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_i       (fifo_item),
    .item_valid_i (fifo_valid),
    .item_ready_o (fifo_ready),
    .m_tvalid_o   (m_axis_tvalid),
    .m_tready_i   (m_axis_tready),
    .m_tdata_o    (m_axis_tdata),
    .m_tuser_o    (m_axis_tuser)
  );

endmodule
`default_nettype wire

/* sv/pket_checker.sv */
`default_nettype none
`include "per_key_event_threshold_table_assert.svh"
module pket_checker (
  input wire                              clk_i,
  input wire                              rst_ni,
  input wire                              s_axis_tvalid,
  input wire                              s_axis_tready,
  input wire                              m_axis_tvalid,
  input wire                              m_axis_tready,
  input wire [pket_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
  input wire [pket_pkg::TUSER_OUT_W-1:0]  m_axis_tuser,
  input wire                              pready
);
  import pket_pkg::*;

  // Beats accepted on the input and not yet delivered on the output.
  logic [3:0] pending_q;
  logic       in_beat, out_beat;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_beat = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_beat && !out_beat) begin
      pending_q <= pending_q + 1'b1;
    end else if (out_beat && !in_beat) begin
      pending_q <= pending_q - 1'b1;
    end
  end

  `PKET_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
  `PKET_ASSERT(a_no_invented, clk_i, rst_ni, m_axis_tvalid |-> pending_q != 4'd0)
  `PKET_ASSERT(a_full_clears, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tdata == '0 && !m_axis_tuser[0])
  `PKET_ASSERT(a_term_counted, clk_i, rst_ni, m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata != '0)
  `PKET_ASSERT_ALWAYS(a_pready, clk_i, pready)

endmodule

bind per_key_event_threshold_table pket_checker u_pket_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .pready        (pready)
);
`default_nettype wire

/* dv/testbench.sv */
module testbench;
  import pket_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_500_000;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned POOL_SIZE = 24;
  localparam logic [PID_W-1:0] PID_MAX = {PID_W{1'b1}};
  localparam logic [APB_ADDR_W-1:0] ADDR_THRESHOLD = {REG_ACCESS_THRESHOLD, 2'b00};
  localparam logic [APB_ADDR_W-1:0] ADDR_MIN_ID = {REG_MIN_FLAG_ID, 2'b00};

  typedef struct packed {
    logic             terminate;
    logic             table_full;
    logic [CNT_W-1:0] count;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   s_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_IN_W-1:0]  s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_tready = 1'b0;
  logic [TDATA_OUT_W-1:0] m_axis_tdata;
  logic [TUSER_OUT_W-1:0] m_axis_tuser;

  logic                  psel_q = 1'b0;
  logic                  penable_q = 1'b0;
  logic                  pwrite_q = 1'b0;
  logic [APB_ADDR_W-1:0] paddr_q = '0;
  logic [APB_DATA_W-1:0] pwdata_q = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  per_key_event_threshold_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel_q),
    .penable       (penable_q),
    .pwrite        (pwrite_q),
    .paddr         (paddr_q),
    .pwdata        (pwdata_q),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Shadow of the id table and of the two limit registers.
  logic [PID_W-1:0] id_slots [ENTRIES] = '{default: '0};
  logic [CNT_W-1:0] hit_counts [ENTRIES] = '{default: '0};
  logic [CNT_W-1:0] threshold_cfg = THRESHOLD_RESET;
  logic [PID_W-1:0] min_id_cfg = MIN_ID_RESET;

  verdict_t pending_verdicts[$];
  int unsigned error_count = 0;
  bit src_idle_on = 1'b1;
  bit sink_idle_on = 1'b1;
  bit hold_off_req = 1'b0;
  logic [PID_W-1:0] pid_pool [POOL_SIZE];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Counts one event against the shadow table and returns the expected beat.
  function automatic verdict_t tally_event(logic [PID_W-1:0] pid, logic modify);
    verdict_t v;
    int hit;
    int free_slot;
    logic [CNT_W-1:0] c;
    v = '0;
    hit = -1;
    free_slot = -1;
    if (!modify || pid == '0) return v;
    for (int i = 0; i < ENTRIES; i++) begin
      if (hit < 0 && id_slots[i] == pid) hit = i;
      if (free_slot < 0 && id_slots[i] == '0) free_slot = i;
    end
    if (hit < 0) begin
      if (free_slot < 0) begin
        v.table_full = 1'b1;
        return v;
      end
      hit = free_slot;
      id_slots[hit] = pid;
    end
    c = hit_counts[hit];
    if (c != CNT_MAX) c = c + 1'b1;
    hit_counts[hit] = c;
    v.terminate = (c >= threshold_cfg) && (pid > min_id_cfg);
    v.count = c;
    return v;
  endfunction

  task automatic send_event(input logic [PID_W-1:0] pid, input logic modify);
    int unsigned gap;
    gap = src_idle_on ? pick_gap() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(TDATA_IN_W - PID_W){1'b0}}, pid};
    s_tuser <= modify;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_verdicts.push_back(tally_event(pid, modify));
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_verdicts.size() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input logic wr, input logic [APB_ADDR_W-1:0] addr,
                            input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    psel_q <= 1'b1;
    penable_q <= 1'b0;
    pwrite_q <= wr;
    paddr_q <= addr;
    pwdata_q <= wdata;
    @(posedge clk_i);
    penable_q <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    psel_q <= 1'b0;
    penable_q <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic check_reg(input logic [APB_ADDR_W-1:0] addr,
                           input logic [APB_DATA_W-1:0] expected);
    logic [APB_DATA_W-1:0] rdata;
    apb_access(1'b0, addr, '0, rdata);
    if (rdata !== expected) begin
      error_count++;
      $display("%0t: register 0x%0h read mismatch: expected 0x%0h, got 0x%0h",
               $time, addr, expected, rdata);
    end
  endtask

  task automatic set_limits(input logic [CNT_W-1:0] thr, input logic [PID_W-1:0] min_id);
    logic [APB_DATA_W-1:0] unused;
    wait_idle();
    apb_access(1'b1, ADDR_THRESHOLD, APB_DATA_W'(thr), unused);
    apb_access(1'b1, ADDR_MIN_ID, APB_DATA_W'(min_id), unused);
    check_reg(ADDR_THRESHOLD, APB_DATA_W'(thr));
    check_reg(ADDR_MIN_ID, APB_DATA_W'(min_id));
    threshold_cfg = thr;
    min_id_cfg = min_id;
  endtask

  // Result checker and receiver stall generator.
  always @(posedge clk_i) begin
    verdict_t want;
    logic next_ready;
    int unsigned stall_left;
    int unsigned hold_left;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_tready) begin
        if (pending_verdicts.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result beat: count=%0d tuser=%b",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = pending_verdicts.pop_front();
          if (m_axis_tuser[0] !== want.terminate || m_axis_tuser[1] !== want.table_full ||
              m_axis_tdata !== want.count) begin
            error_count++;
            $display("%0t: result mismatch: expected terminate=%0b table_full=%0b count=%0d,",
                     $time, want.terminate, want.table_full, want.count,
                     " got terminate=%0b table_full=%0b count=%0d",
                     m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata);
          end
        end
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        next_ready = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        next_ready = 1'b0;
      end else if (sink_idle_on && $urandom_range(0, 3) == 0) begin
        stall_left = pick_gap();
        next_ready = 1'b0;
      end else begin
        next_ready = 1'b1;
      end
      m_tready <= next_ready;
    end
  end

  initial begin
    int unsigned cycles;
    cycles = 0;
    wait (rst_ni);
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("** per_key_event_threshold_table: FAILED **");
    $finish;
  end

  task automatic test_directed_defaults();
    check_reg(ADDR_THRESHOLD, APB_DATA_W'(THRESHOLD_RESET));
    check_reg(ADDR_MIN_ID, APB_DATA_W'(MIN_ID_RESET));
    send_event(PID_MAX, 1'b0);
    send_event('0, 1'b1);
    send_event('0, 1'b0);
    send_event(PID_W'(1), 1'b1);
    send_event(PID_MAX, 1'b1);
    send_event(MIN_ID_RESET, 1'b1);
    send_event(MIN_ID_RESET + 1'b1, 1'b1);
  endtask

  task automatic test_directed_limits();
    set_limits(CNT_W'(1), MIN_ID_RESET);
    send_event(MIN_ID_RESET, 1'b1);
    send_event(MIN_ID_RESET + 1'b1, 1'b1);
    send_event(PID_MAX, 1'b1);
    send_event(PID_W'(1), 1'b1);
    // A zero threshold flags every counted event of an eligible id.
    set_limits('0, '0);
    send_event(PID_W'(1), 1'b1);
    send_event(MIN_ID_RESET, 1'b1);
    send_event(MIN_ID_RESET + 1'b1, 1'b0);
    set_limits(CNT_MAX, PID_MAX);
    send_event(PID_MAX, 1'b1);
    send_event(PID_W'(1), 1'b1);
  endtask

  task automatic random_phase(input int unsigned counted_target);
    int unsigned counted;
    int unsigned r;
    logic [PID_W-1:0] pid;
    logic modify;
    counted = 0;
    while (counted < counted_target) begin
      if (counted % 100 == 0) begin
        src_idle_on = ($urandom_range(0, 3) != 0);
        sink_idle_on = ($urandom_range(0, 3) != 0);
      end
      r = $urandom_range(0, 99);
      modify = 1'b1;
      if (r < 70) begin
        pid = pid_pool[$urandom_range(0, POOL_SIZE - 1)];
      end else if (r < 82) begin
        pid = PID_W'($urandom_range(1, int'(PID_MAX)));
      end else if (r < 94) begin
        pid = PID_W'($urandom);
        modify = 1'b0;
      end else begin
        pid = '0;
      end
      send_event(pid, modify);
      if (modify && pid != '0) counted++;
    end
  endtask

  task automatic test_random_traffic();
    pid_pool[0] = PID_W'(1);
    pid_pool[1] = PID_MAX;
    pid_pool[2] = MIN_ID_RESET;
    pid_pool[3] = MIN_ID_RESET + 1'b1;
    for (int i = 4; i < POOL_SIZE; i++) begin
      if (i % 2 == 0) pid_pool[i] = PID_W'($urandom_range(1, 16000));
      else pid_pool[i] = PID_W'($urandom_range(1, int'(PID_MAX)));
    end
    set_limits(THRESHOLD_RESET, MIN_ID_RESET);
    random_phase(400);
    set_limits(CNT_W'(1), '0);
    random_phase(400);
    set_limits(CNT_W'($urandom_range(20, 80)), PID_W'($urandom_range(0, 16000)));
    random_phase(400);
    set_limits(CNT_MAX, PID_MAX);
    random_phase(400);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    set_limits(CNT_W'($urandom_range(30, 120)), PID_W'($urandom_range(0, 9000)));
    src_idle_on = 1'b0;
    hold_off_req = 1'b1;
    repeat (40) send_event(pid_pool[$urandom_range(0, POOL_SIZE - 1)], 1'b1);
    src_idle_on = 1'b1;
  endtask

  task automatic test_table_full();
    logic [PID_W-1:0] fresh;
    fresh = PID_W'($urandom_range(16001, int'(PID_MAX) - 1));
    send_event(fresh, 1'b1);
    send_event(fresh, 1'b1);
    send_event(fresh, 1'b0);
    send_event(pid_pool[0], 1'b1);
    send_event(pid_pool[3], 1'b1);
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_defaults();
    test_directed_limits();
    test_random_traffic();
    test_backpressure();
    test_table_full();
    wait_idle();
    repeat (12) @(posedge clk_i);
    if (error_count == 0) begin
      $display("** per_key_event_threshold_table: PASSED **");
    end else begin
      $display("** per_key_event_threshold_table: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/pket_pkg.sv
sv/pket_front.sv
sv/pket_fifo.sv
sv/pket_back.sv
sv/per_key_event_threshold_table.sv
sv/pket_checker.sv
dv/testbench.sv
